// ----- rtl/core/epas_pkg.sv -----
package epas_pkg;

    // Default sizes of the block.
    localparam int CHANNELS_DEF = 4;
    localparam int AVG_TAPS_DEF = 5;

    // Field widths.
    localparam int CH_FIELD_W = 2;
    localparam int CAP_W      = 16;
    localparam int WIDTH_W    = 16;
    localparam int SPEED_W    = 24;
    localparam int NUM_W      = 24;
    localparam int TOL_W      = 8;

    // Stream and configuration port widths.
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 48;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 24;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_NUM   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STALL_TOL   = 2'd2;

    // Register values after reset.
    localparam logic [NUM_W-1:0]   SPEED_NUM_RST   = 24'd1390000;
    localparam logic [WIDTH_W-1:0] WIDTH_LIMIT_RST = 16'd30000;
    localparam logic [TOL_W-1:0]   STALL_TOL_RST   = 8'd5;

    // Kind of an input word.
    typedef enum logic {
        FUNC_CAPTURE = 1'b0,
        FUNC_REPORT  = 1'b1
    } t_func;

    // Sequencer states.
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_LOAD  = 7'b0000010,
        S_DIV   = 7'b0000100,
        S_EMIT  = 7'b0001000,
        S_WRITE = 7'b0010000,
        S_SUM   = 7'b0100000,
        S_FIN   = 7'b1000000
    } t_state;

endpackage

// ----- rtl/core/encoder_period_average_speed_unit.sv -----
// Encoder speed unit for CHANNELS channels. A capture word (tuser = 0) carries a channel and a
// timer count; when the count is above that channel's previous one, the difference enters an
// AVG_TAPS-deep history and the pulse width becomes the sum of each entry divided by AVG_TAPS.
// The sum makes one history-memory read and one reciprocal multiply per entry; a capture that
// does not raise the count only records it as the previous count. A report word (tuser = 1)
// returns one word per channel in channel order with the speed in hundredths, numerator / width
// (zero when the width is zero or at or above the limit), and the width, tlast on the last
// channel; then the width enters a second history and is cleared when it lies within the
// tolerance of that history's average. Each channel uses a 24-step restoring divider, skipped
// for an invalid width, the same history sum, and any wait for the output register to drain.
// The block takes no new word while a capture or report is in progress.
module encoder_period_average_speed_unit #(
    parameter int CHANNELS = epas_pkg::CHANNELS_DEF,
    parameter int AVG_TAPS = epas_pkg::AVG_TAPS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Input stream.
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // tdata: channel [1:0], capture_value [17:2], zero fill above.
    input  logic [epas_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // tuser: func.
    input  logic                                 s_axis_tuser,
    // Output stream.
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // tdata: out_channel [1:0], speed_centi [25:2], avg_width [41:26], zero fill above.
    output logic [epas_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // tlast: last.
    output logic                                 m_axis_tlast,
    // Configuration write port.
    input  logic                                 i_cfg_we,
    input  logic [epas_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [epas_pkg::CFG_DATA_W-1:0]      i_cfg_wdata
);

    localparam int CH_W        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int TAP_W       = $clog2(AVG_TAPS);
    localparam int ADDR_W      = 1 + CH_W + TAP_W;
    localparam int MEM_DEPTH   = 1 << ADDR_W;
    localparam int WIDTH_W     = epas_pkg::WIDTH_W;
    localparam int NUM_W       = epas_pkg::NUM_W;
    localparam int RECIP_SHIFT = WIDTH_W + TAP_W;
    localparam int RECIP_W     = WIDTH_W + 1;
    localparam int PROD_W      = RECIP_SHIFT + WIDTH_W;
    localparam int SUM_LAST    = AVG_TAPS + 1;
    localparam int CNT_MAX     = (SUM_LAST > NUM_W) ? SUM_LAST : NUM_W;
    localparam int CNT_W       = $clog2(CNT_MAX + 1);
    localparam int OUT_PAD_W   = epas_pkg::OUT_TDATA_W
                                 - (epas_pkg::CH_FIELD_W + epas_pkg::SPEED_W + WIDTH_W);
    // Rounded-up reciprocal: floor(x * RECIP_MULT >> RECIP_SHIFT) equals x / AVG_TAPS
    // for every 16-bit x.
    localparam logic [RECIP_W-1:0] RECIP_MULT =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(AVG_TAPS) - 64'd1) / 64'(AVG_TAPS));

    epas_pkg::t_state n_state;
    epas_pkg::t_state r_state;

    // Configuration registers.
    logic [NUM_W-1:0]          r_num;
    logic [WIDTH_W-1:0]        r_limit;
    logic [epas_pkg::TOL_W-1:0] r_tol;

    // Per-channel state.
    logic [epas_pkg::CAP_W-1:0] r_last_cap [CHANNELS];
    logic [WIDTH_W-1:0]         r_pw       [CHANNELS];
    logic [TAP_W-1:0]           r_chead    [CHANNELS];
    logic [TAP_W-1:0]           r_shead    [CHANNELS];

    // History memory: capture histories in the lower half, stall histories in the upper.
    logic [WIDTH_W-1:0]   r_mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0] r_mem_ok;

    // Sequencer working registers.
    epas_pkg::t_func      r_func;
    logic [CH_W-1:0]      r_ch;
    logic [WIDTH_W-1:0]   r_entry;
    logic [WIDTH_W-1:0]   r_w;
    logic [CNT_W-1:0]     r_cnt;
    logic [WIDTH_W-1:0]   r_rem;
    logic [NUM_W-1:0]     r_quo;
    logic [WIDTH_W-1:0]   r_sum;

    // Sum pipeline.
    logic [WIDTH_W-1:0]   r_rd_data;
    logic                 r_rd_ok;
    logic                 r_rd_vld;
    logic [PROD_W-1:0]    r_prod;
    logic                 r_prod_vld;

    // Output register.
    logic                               r_m_valid;
    logic [epas_pkg::CH_FIELD_W-1:0]    r_m_ch;
    logic [epas_pkg::SPEED_W-1:0]       r_m_speed;
    logic [WIDTH_W-1:0]                 r_m_width;
    logic                               r_m_last;

    logic                        in_accept;
    epas_pkg::t_func             in_func;
    logic [CH_W-1:0]             in_ch;
    logic [epas_pkg::CAP_W-1:0]  in_cap;
    logic                        ch_ok;
    logic                        cap_up;
    logic                        out_free;
    logic                        hsel;
    logic [TAP_W-1:0]            wr_head;
    logic [TAP_W-1:0]            head_inc;
    logic [ADDR_W-1:0]           wr_addr;
    logic [ADDR_W-1:0]           rd_addr;
    logic                        rd_en;
    logic [WIDTH_W-1:0]          rd_val;
    logic [WIDTH_W-1:0]          w_cur;
    logic                        speed_ok;
    logic [WIDTH_W:0]            rem_sh;
    logic                        fits;
    logic [WIDTH_W-1:0]          rem_next;
    logic [WIDTH_W-1:0]          diff;
    logic                        stalled;
    logic                        last_ch;

    // Input decode.
    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign in_func   = epas_pkg::t_func'(s_axis_tuser);
    assign in_ch     = CH_W'(s_axis_tdata[1:0]);
    assign in_cap    = s_axis_tdata[2 +: epas_pkg::CAP_W];
    assign ch_ok     = (32'(s_axis_tdata[1:0]) < 32'(CHANNELS));
    assign cap_up    = ch_ok && (in_cap > r_last_cap[in_ch]);

    // History addressing: a row per channel, used as a ring through its head pointer.
    assign hsel     = (r_func == epas_pkg::FUNC_REPORT);
    assign wr_head  = hsel ? r_shead[r_ch] : r_chead[r_ch];
    assign head_inc = (wr_head == TAP_W'(AVG_TAPS - 1)) ? '0 : wr_head + TAP_W'(1);
    assign wr_addr  = {hsel, r_ch, wr_head};
    assign rd_addr  = {hsel, r_ch, r_cnt[TAP_W-1:0]};
    assign rd_en    = (r_state == epas_pkg::S_SUM) && (r_cnt < CNT_W'(AVG_TAPS));
    assign rd_val   = r_rd_ok ? r_rd_data : '0;

    // Width check and one restoring divider step.
    assign w_cur    = r_pw[r_ch];
    assign speed_ok = (w_cur != '0) && (w_cur < r_limit);
    assign rem_sh   = {r_rem, r_quo[NUM_W-1]};
    assign fits     = (rem_sh >= {1'b0, r_w});
    assign rem_next = fits ? WIDTH_W'(rem_sh - {1'b0, r_w}) : rem_sh[WIDTH_W-1:0];

    // Stall check against the history average.
    assign diff    = (r_w >= r_sum) ? (r_w - r_sum) : (r_sum - r_w);
    assign stalled = (diff <= {{(WIDTH_W - epas_pkg::TOL_W){1'b0}}, r_tol});
    assign last_ch = (r_ch == CH_W'(CHANNELS - 1));

    assign out_free = !r_m_valid || m_axis_tready;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            epas_pkg::S_IDLE: begin
                if (in_accept) begin
                    if (in_func == epas_pkg::FUNC_REPORT) begin
                        n_state = epas_pkg::S_LOAD;
                    end else if (cap_up) begin
                        n_state = epas_pkg::S_WRITE;
                    end
                end
            end
            epas_pkg::S_LOAD: begin
                n_state = speed_ok ? epas_pkg::S_DIV : epas_pkg::S_EMIT;
            end
            epas_pkg::S_DIV: begin
                if (r_cnt == CNT_W'(NUM_W - 1)) begin
                    n_state = epas_pkg::S_EMIT;
                end
            end
            epas_pkg::S_EMIT: begin
                if (out_free) begin
                    n_state = epas_pkg::S_WRITE;
                end
            end
            epas_pkg::S_WRITE: begin
                n_state = epas_pkg::S_SUM;
            end
            epas_pkg::S_SUM: begin
                if (r_cnt == CNT_W'(SUM_LAST)) begin
                    n_state = epas_pkg::S_FIN;
                end
            end
            epas_pkg::S_FIN: begin
                if (hsel && !last_ch) begin
                    n_state = epas_pkg::S_LOAD;
                end else begin
                    n_state = epas_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = epas_pkg::S_IDLE;
            end
        endcase
    end

    // Control state, configuration and per-channel state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= epas_pkg::S_IDLE;
            r_num      <= epas_pkg::SPEED_NUM_RST;
            r_limit    <= epas_pkg::WIDTH_LIMIT_RST;
            r_tol      <= epas_pkg::STALL_TOL_RST;
            r_mem_ok   <= '0;
            r_cnt      <= '0;
            r_rd_vld   <= 1'b0;
            r_prod_vld <= 1'b0;
            r_m_valid  <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_last_cap[i] <= '0;
                r_pw[i]       <= '0;
                r_chead[i]    <= '0;
                r_shead[i]    <= '0;
            end
        end else begin
            r_state    <= n_state;
            r_rd_vld   <= rd_en;
            r_prod_vld <= r_rd_vld;

            // Configuration writes; indexes beyond the list are dropped.
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    epas_pkg::CFG_SPEED_NUM:   r_num   <= i_cfg_wdata[NUM_W-1:0];
                    epas_pkg::CFG_WIDTH_LIMIT: r_limit <= i_cfg_wdata[WIDTH_W-1:0];
                    epas_pkg::CFG_STALL_TOL:   r_tol   <= i_cfg_wdata[epas_pkg::TOL_W-1:0];
                    default: begin
                    end
                endcase
            end

            // The previous capture always follows a valid channel's count.
            if (r_state == epas_pkg::S_IDLE && in_accept
                && in_func == epas_pkg::FUNC_CAPTURE && ch_ok) begin
                r_last_cap[in_ch] <= in_cap;
            end

            // Step counter for the divider and the sum sweep.
            priority case (1'b1)
                (r_state == epas_pkg::S_LOAD):  r_cnt <= '0;
                (r_state == epas_pkg::S_WRITE): r_cnt <= '0;
                (r_state == epas_pkg::S_DIV):   r_cnt <= r_cnt + CNT_W'(1);
                (r_state == epas_pkg::S_SUM):   r_cnt <= r_cnt + CNT_W'(1);
                default: begin
                end
            endcase

            // New history entry goes in at the head, which then moves on.
            if (r_state == epas_pkg::S_WRITE) begin
                r_mem_ok[wr_addr] <= 1'b1;
                if (hsel) begin
                    r_shead[r_ch] <= head_inc;
                end else begin
                    r_chead[r_ch] <= head_inc;
                end
            end

            // Width update: new average on a capture, cleared on a stalled report.
            if (r_state == epas_pkg::S_FIN) begin
                if (!hsel) begin
                    r_pw[r_ch] <= r_sum;
                end else if (stalled) begin
                    r_pw[r_ch] <= '0;
                end
            end

            // Output register handshake.
            if (r_state == epas_pkg::S_EMIT && out_free) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Sequencer datapath.
    always_ff @(posedge i_clk) begin
        if (r_state == epas_pkg::S_IDLE && in_accept) begin
            r_func  <= in_func;
            r_ch    <= (in_func == epas_pkg::FUNC_REPORT) ? '0 : in_ch;
            r_entry <= in_cap - r_last_cap[in_ch];
        end
        if (r_state == epas_pkg::S_LOAD) begin
            r_w   <= w_cur;
            r_rem <= '0;
            r_quo <= speed_ok ? r_num : '0;
        end
        if (r_state == epas_pkg::S_DIV) begin
            r_rem <= rem_next;
            r_quo <= {r_quo[NUM_W-2:0], fits};
        end
        if (r_state == epas_pkg::S_EMIT && out_free) begin
            r_entry   <= r_w;
            r_m_ch    <= epas_pkg::CH_FIELD_W'(r_ch);
            r_m_speed <= r_quo;
            r_m_width <= r_w;
            r_m_last  <= last_ch;
        end
        if (r_state == epas_pkg::S_WRITE) begin
            r_sum <= '0;
        end
        if (r_state == epas_pkg::S_SUM && r_prod_vld) begin
            r_sum <= r_sum + r_prod[RECIP_SHIFT +: WIDTH_W];
        end
        if (r_state == epas_pkg::S_FIN && hsel && !last_ch) begin
            r_ch <= r_ch + CH_W'(1);
        end
    end

    // History memory, one write and one read port.
    always_ff @(posedge i_clk) begin
        if (r_state == epas_pkg::S_WRITE) begin
            r_mem[wr_addr] <= r_entry;
        end
        r_rd_data <= r_mem[rd_addr];
        r_rd_ok   <= r_mem_ok[rd_addr];
    end

    // Shared reciprocal multiplier: one history entry divided by the tap count per cycle.
    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(rd_val) * PROD_W'(RECIP_MULT);
    end

    assign s_axis_tready = (r_state == epas_pkg::S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, r_m_width, r_m_speed, r_m_ch};
    assign m_axis_tlast  = r_m_last;

    // The divider remainder stays below the divisor.
    a_rem_below_divisor: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == epas_pkg::S_DIV) |-> (r_rem < r_w)
    ) else $error("divider remainder not below divisor");

    // Products reach the accumulator only during the sum sweep.
    a_prod_in_sum: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        r_prod_vld |-> (r_state == epas_pkg::S_SUM)
    ) else $error("history product outside the sum sweep");

    // A history head never points past the last tap.
    a_head_in_range: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == epas_pkg::S_WRITE) |-> (32'(wr_head) < 32'(AVG_TAPS))
    ) else $error("history head out of range");

    // An invalid width always reports zero speed.
    a_zero_speed: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == epas_pkg::S_EMIT && (r_w == '0 || r_w >= r_limit)) |-> (r_quo == '0)
    ) else $error("nonzero speed for an invalid width");

endmodule
